[sv/bzs_pkg.sv]
package bzs_pkg;

  // Fixed field widths of the block.
  localparam int DUR_W     = 16;
  localparam int STEP_W    = 16;
  localparam int ELAPSED_W = 32;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_DX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_DY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd6;

  // Status of the curve parameter divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/bzs_divider.sv]
module bzs_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bzs_pkg::DUR_W-1:0]    num,
  input  logic [bzs_pkg::DUR_W-1:0]    den,
  output logic [FRAC_BITS:0]           quot,
  output bzs_pkg::div_stat_t           stat
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [bzs_pkg::DUR_W-1:0] rem_r;
  logic [FRAC_BITS:0]        quot_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [bzs_pkg::DUR_W:0]   rem_sh;
  logic [bzs_pkg::DUR_W:0]   rem_sub;
  logic                      ge;
  logic                      start_ge;

  // One quotient bit per cycle: shift the remainder and try the divisor.
  assign rem_sh   = {rem_r, 1'b0};
  assign rem_sub  = rem_sh - {1'b0, den};
  assign ge       = (rem_sh >= {1'b0, den});
  assign start_ge = (num >= den);

  // Sequencing of the iterations.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FRAC_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // The numerator never exceeds the divisor, so the integer part is a single bit.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= start_ge ? (num - den) : num;
      quot_r <= (FRAC_BITS + 1)'(start_ge);
    end else if (busy_r) begin
      rem_r  <= ge ? rem_sub[bzs_pkg::DUR_W-1:0] : rem_sh[bzs_pkg::DUR_W-1:0];
      quot_r <= {quot_r[FRAC_BITS-1:0], ge};
    end
  end

  assign quot      = quot_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[sv/bzs_lerp_unit.sv]
module bzs_lerp_unit #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         mul_en,
  input  logic signed [COORD_BITS-1:0] p,
  input  logic signed [COORD_BITS-1:0] q,
  input  logic [FRAC_BITS:0]           t,
  output logic signed [COORD_BITS-1:0] res
);

  localparam int PW = COORD_BITS + FRAC_BITS + 3;
  localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (FRAC_BITS - 1));

  logic signed [COORD_BITS:0]  diff;
  logic signed [FRAC_BITS+1:0] t_s;
  logic signed [PW-1:0]        prod_nxt;
  logic signed [PW-1:0]        prod_r;
  logic signed [PW-1:0]        rnd;
  logic signed [PW-1:0]        fl;
  logic signed [PW-1:0]        sum;

  // Multiply step: difference times t, registered.
  assign diff     = (COORD_BITS + 1)'(q) - (COORD_BITS + 1)'(p);
  assign t_s      = $signed({1'b0, t});
  assign prod_nxt = diff * t_s;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Output step, from the registered product: round half up, floor by arithmetic shift, add the start point.
  assign rnd = prod_r + HALF;
  assign fl  = rnd >>> FRAC_BITS;
  assign sum = PW'(p) + fl;
  assign res = sum[COORD_BITS-1:0];

endmodule

[sv/cubic_bezier_motion_stepper.sv]
// Channel | Direction | tdata (low bit up)                      | tuser
// in_     | input     | time_step                               | action
// out_    | output    | offset_x, offset_y, velocity_x, vel._y  | reached
// cfg_    | input     | cfg_index selects, cfg_data carries the value
//
// A tick that lands on the curve passes one compare, the bit-serial divider for t,
// and then, per axis, the shared lerp multiplier (six lerps and three shift steps).
// A tick past the end goes from the compare straight to the output. A stop item,
// or a tick while stopped, is absorbed in the cycle it is accepted.
// Input is taken only when idle.
// A finished result waits in the output register while the next item is taken.
// Reset is synchronous and active low; configuration writes are always accepted.
module cubic_bezier_motion_stepper #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16,
  localparam int OUT_W = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int CFG_W = (COORD_BITS > bzs_pkg::DUR_W) ? COORD_BITS : bzs_pkg::DUR_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bzs_pkg::STEP_W-1:0]      in_tdata,   // time_step
  input  logic                            in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata,  // offset_x, offset_y, velocity_x,
                                                      // velocity_y, zero fill
  output logic                            out_tuser,  // reached
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bzs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]                cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // De Casteljau schedule per axis: lerp, lerp, lerp, drop, lerp, lerp, drop,
  // drop, lerp. Bit i set means step i is a lerp.
  localparam int         NUM_STEPS    = 9;
  localparam logic [8:0] STEP_IS_LERP = 9'b100110111;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic [2:0]                        state_r;
  logic signed [COORD_BITS-1:0]      ctrl1_x_r, ctrl1_y_r, ctrl2_x_r, ctrl2_y_r;
  logic signed [COORD_BITS-1:0]      end_dx_r, end_dy_r;
  logic [bzs_pkg::DUR_W-1:0]         dur_r;
  logic [bzs_pkg::DUR_W-1:0]         dur_eff;
  logic [bzs_pkg::ELAPSED_W-1:0]     elapsed_r;
  logic [bzs_pkg::ELAPSED_W:0]       elapsed_sum;
  logic [bzs_pkg::ELAPSED_W-1:0]     elapsed_nxt;
  logic                              stopped_r;
  logic signed [COORD_BITS-1:0]      last_x_r, last_y_r;
  logic signed [COORD_BITS-1:0]      ox_r, oy_r;
  logic signed [COORD_BITS-1:0]      w_r [4];
  logic [3:0]                        step_r;
  logic                              phase_r;
  logic                              axis_r;
  logic                              reached_r;
  logic                              out_tvalid_r;
  logic signed [COORD_BITS-1:0]      out_ox_r, out_oy_r, out_vx_r, out_vy_r;
  logic                              out_reached_r;
  logic                              in_acc;
  logic                              past_end;
  logic                              div_start;
  logic [FRAC_BITS:0]                t_q;
  bzs_pkg::div_stat_t                div_stat;
  logic                              is_lerp;
  logic                              mul_en;
  logic                              do_shift;
  logic                              last_step;
  logic signed [COORD_BITS-1:0]      lerp_res;
  logic                              out_load;
  logic signed [COORD_BITS:0]        dx, dy;
  logic signed [COORD_BITS-1:0]      vx_sat, vy_sat;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // A zero duration counts as one.
  assign dur_eff = (dur_r == '0) ? bzs_pkg::DUR_W'(1) : dur_r;

  // Saturating elapsed-time update.
  assign elapsed_sum = {1'b0, elapsed_r} + (bzs_pkg::ELAPSED_W + 1)'(in_tdata);
  assign elapsed_nxt = elapsed_sum[bzs_pkg::ELAPSED_W] ? '1
                                                       : elapsed_sum[bzs_pkg::ELAPSED_W-1:0];

  assign past_end  = (elapsed_r > bzs_pkg::ELAPSED_W'(dur_eff));
  assign div_start = (state_r == ST_CMP) && !past_end;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_x_r <= '0;
      ctrl1_y_r <= '0;
      ctrl2_x_r <= '0;
      ctrl2_y_r <= '0;
      end_dx_r  <= '0;
      end_dy_r  <= '0;
      dur_r     <= bzs_pkg::DUR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bzs_pkg::REG_CTRL1_X:  ctrl1_x_r <= cfg_data[COORD_BITS-1:0];
        bzs_pkg::REG_CTRL1_Y:  ctrl1_y_r <= cfg_data[COORD_BITS-1:0];
        bzs_pkg::REG_CTRL2_X:  ctrl2_x_r <= cfg_data[COORD_BITS-1:0];
        bzs_pkg::REG_CTRL2_Y:  ctrl2_y_r <= cfg_data[COORD_BITS-1:0];
        bzs_pkg::REG_END_DX:   end_dx_r  <= cfg_data[COORD_BITS-1:0];
        bzs_pkg::REG_END_DY:   end_dy_r  <= cfg_data[COORD_BITS-1:0];
        bzs_pkg::REG_DURATION: dur_r     <= cfg_data[bzs_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Bit-serial divider for t = elapsed * 2^FRAC_BITS / duration.
  bzs_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (elapsed_r[bzs_pkg::DUR_W-1:0]),
    .den   (dur_eff),
    .quot  (t_q),
    .stat  (div_stat)
  );

  // Shared lerp unit, always fed from the two head places of the shift line.
  assign is_lerp   = STEP_IS_LERP[step_r];
  assign mul_en    = (state_r == ST_RUN) && is_lerp && !phase_r;
  assign do_shift  = (state_r == ST_RUN) && (!is_lerp || phase_r);
  assign last_step = (step_r == 4'(NUM_STEPS - 1));

  bzs_lerp_unit #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lerp (
    .clk    (clk),
    .mul_en (mul_en),
    .p      (w_r[0]),
    .q      (w_r[1]),
    .t      (t_q),
    .res    (lerp_res)
  );

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      elapsed_r <= '0;
      stopped_r <= 1'b0;
      step_r    <= '0;
      phase_r   <= 1'b0;
      axis_r    <= 1'b0;
      reached_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser) begin
              stopped_r <= 1'b1;
            end else if (!stopped_r) begin
              elapsed_r <= elapsed_nxt;
              state_r   <= ST_CMP;
            end
          end
        end
        ST_CMP: begin
          reached_r <= past_end;
          state_r   <= past_end ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            step_r  <= '0;
            phase_r <= 1'b0;
            axis_r  <= 1'b0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (mul_en) begin
            phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            if (last_step) begin
              step_r <= '0;
              axis_r <= 1'b1;
              if (axis_r) begin
                state_r <= ST_OUT;
              end
            end else begin
              step_r <= step_r + 4'd1;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Point shift line: load an axis, shift one place per step, lerp result enters at the tail.
  always_ff @(posedge clk) begin
    if ((state_r == ST_DIV) && div_stat.done) begin
      w_r[0] <= '0;
      w_r[1] <= ctrl1_x_r;
      w_r[2] <= ctrl2_x_r;
      w_r[3] <= end_dx_r;
    end else if (do_shift && last_step && !axis_r) begin
      w_r[0] <= '0;
      w_r[1] <= ctrl1_y_r;
      w_r[2] <= ctrl2_y_r;
      w_r[3] <= end_dy_r;
    end else if (do_shift) begin
      w_r[0] <= w_r[1];
      w_r[1] <= w_r[2];
      w_r[2] <= w_r[3];
      if (is_lerp) begin
        w_r[3] <= lerp_res;
      end
    end
  end

  // Capture the final point of each axis.
  always_ff @(posedge clk) begin
    if (do_shift && last_step) begin
      if (axis_r) begin
        oy_r <= lerp_res;
      end else begin
        ox_r <= lerp_res;
      end
    end
  end

  // Velocity with saturation to the coordinate range.
  assign dx     = (COORD_BITS + 1)'(ox_r) - (COORD_BITS + 1)'(last_x_r);
  assign dy     = (COORD_BITS + 1)'(oy_r) - (COORD_BITS + 1)'(last_y_r);
  assign vx_sat = (dx[COORD_BITS] != dx[COORD_BITS-1]) ?
                  (dx[COORD_BITS] ? COORD_MIN : COORD_MAX) : dx[COORD_BITS-1:0];
  assign vy_sat = (dy[COORD_BITS] != dy[COORD_BITS-1]) ?
                  (dy[COORD_BITS] ? COORD_MIN : COORD_MAX) : dy[COORD_BITS-1:0];

  assign out_load = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  // Output register and previous-offset state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      last_x_r     <= '0;
      last_y_r     <= '0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        if (!reached_r) begin
          last_x_r <= ox_r;
          last_y_r <= oy_r;
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reached_r <= reached_r;
      if (reached_r) begin
        out_ox_r <= last_x_r;
        out_oy_r <= last_y_r;
        out_vx_r <= '0;
        out_vy_r <= '0;
      end else begin
        out_ox_r <= ox_r;
        out_oy_r <= oy_r;
        out_vx_r <= vx_sat;
        out_vy_r <= vy_sat;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({out_vy_r, out_vx_r, out_oy_r, out_ox_r});
  assign out_tuser  = out_reached_r;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (t_q <= (FRAC_BITS + 1)'(64'd1 << FRAC_BITS)))
    else $error("curve parameter above one");

  a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stop flag cleared without reset");

  a_elapsed_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (elapsed_r >= $past(elapsed_r)))
    else $error("elapsed time went backward");

  a_reached_still: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_reached_r) |-> ((out_vx_r == '0) && (out_vy_r == '0)))
    else $error("reached result with nonzero velocity");
`endif

endmodule

[bench/cubic_bezier_motion_stepper_test.sv]
`timescale 1ns / 100ps

module cubic_bezier_motion_stepper_test;

  localparam int COORD = 24;
  localparam int FRAC = 16;
  localparam int OUT_W = 4 * COORD;
  localparam int IDLE_PCT = 11;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PHASES = 12;
  localparam int FAR_TICKS = 40;
  localparam logic [COORD-1:0] COORD_MAX = 24'h7FFFFF;
  localparam logic [COORD-1:0] COORD_MIN = 24'h800000;
  localparam logic [bzs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [bzs_pkg::CFG_IDX_W-1:0] REG_ORDER[7] = '{
    bzs_pkg::REG_CTRL1_X, bzs_pkg::REG_CTRL1_Y, bzs_pkg::REG_CTRL2_X,
    bzs_pkg::REG_CTRL2_Y, bzs_pkg::REG_END_DX, bzs_pkg::REG_END_DY,
    bzs_pkg::REG_DURATION};

  typedef enum logic {ACT_TICK = 1'b0, ACT_STOP = 1'b1} action_t;

  typedef struct {
    logic [COORD-1:0] off_x;
    logic [COORD-1:0] off_y;
    logic [COORD-1:0] vel_x;
    logic [COORD-1:0] vel_y;
    logic             reached;
  } point_t;

  // Tracks the move on the curve and holds the points still owed by the block.
  class curve_tracker;
    longint pt[6];
    longint unsigned duration;
    bit [31:0] elapsed;
    bit stopped;
    longint last_x;
    longint last_y;
    point_t pending_points[$];
    int bad_points;
    int reported;

    function new();
      foreach (pt[i]) pt[i] = 0;
      duration = 1;
      elapsed = 0;
      stopped = 0;
      last_x = 0;
      last_y = 0;
      bad_points = 0;
      reported = 0;
    endfunction

    function void write_reg(logic [bzs_pkg::CFG_IDX_W-1:0] idx, logic [COORD-1:0] value);
      case (idx)
        bzs_pkg::REG_CTRL1_X, bzs_pkg::REG_CTRL1_Y, bzs_pkg::REG_CTRL2_X,
        bzs_pkg::REG_CTRL2_Y, bzs_pkg::REG_END_DX, bzs_pkg::REG_END_DY: begin
          pt[idx] = longint'($signed(value));
        end
        bzs_pkg::REG_DURATION: begin
          duration = value[bzs_pkg::DUR_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // One de Casteljau stage: p + (q - p) * t, rounded half up.
    function longint blend(longint p, longint q, longint t);
      longint prod;
      prod = (q - p) * t + (longint'(1) << (FRAC - 1));
      return p + (prod >>> FRAC);
    endfunction

    function longint casteljau(longint b, longint c, longint d, longint t);
      longint p01, p12, p23, q0, q1;
      p01 = blend(0, b, t);
      p12 = blend(b, c, t);
      p23 = blend(c, d, t);
      q0 = blend(p01, p12, t);
      q1 = blend(p12, p23, t);
      return blend(q0, q1, t);
    endfunction

    function longint clamp(longint v);
      longint hi, lo;
      hi = longint'($signed(COORD_MAX));
      lo = longint'($signed(COORD_MIN));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void note_item(action_t act, logic [bzs_pkg::STEP_W-1:0] step);
      longint unsigned sum, num, dur;
      longint t, ox, oy, vx, vy;
      point_t nxt;
      if (act == ACT_STOP) begin
        stopped = 1;
        return;
      end
      if (stopped) return;
      sum = elapsed;
      sum = sum + step;
      elapsed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      dur = (duration == 0) ? 1 : duration;
      if (elapsed > dur) begin
        // Past the end the point stays put and the state is left alone.
        nxt.off_x = last_x[COORD-1:0];
        nxt.off_y = last_y[COORD-1:0];
        nxt.vel_x = '0;
        nxt.vel_y = '0;
        nxt.reached = 1'b1;
      end else begin
        num = elapsed;
        num = num << FRAC;
        t = num / dur;
        ox = casteljau(pt[0], pt[2], pt[4], t);
        oy = casteljau(pt[1], pt[3], pt[5], t);
        vx = clamp(ox - last_x);
        vy = clamp(oy - last_y);
        last_x = ox;
        last_y = oy;
        nxt.off_x = ox[COORD-1:0];
        nxt.off_y = oy[COORD-1:0];
        nxt.vel_x = vx[COORD-1:0];
        nxt.vel_y = vy[COORD-1:0];
        nxt.reached = 1'b0;
      end
      pending_points.push_back(nxt);
    endfunction

    function void check_point(logic [OUT_W-1:0] data, logic reached);
      point_t got, want;
      got.off_x = data[COORD-1:0];
      got.off_y = data[2*COORD-1:COORD];
      got.vel_x = data[3*COORD-1:2*COORD];
      got.vel_y = data[4*COORD-1:3*COORD];
      got.reached = reached;
      if (pending_points.size() == 0) begin
        bad_points++;
        if (reported < 10)
          $display("unexpected point: off %0d,%0d vel %0d,%0d reached %0b",
                   $signed(got.off_x), $signed(got.off_y), $signed(got.vel_x),
                   $signed(got.vel_y), got.reached);
        reported++;
        return;
      end
      want = pending_points.pop_front();
      if (got.off_x !== want.off_x || got.off_y !== want.off_y ||
          got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
          got.reached !== want.reached) begin
        bad_points++;
        if (reported < 10) begin
          $display("point mismatch: expected off %0d,%0d vel %0d,%0d reached %0b",
                   $signed(want.off_x), $signed(want.off_y), $signed(want.vel_x),
                   $signed(want.vel_y), want.reached);
          $display("                got      off %0d,%0d vel %0d,%0d reached %0b",
                   $signed(got.off_x), $signed(got.off_y), $signed(got.vel_x),
                   $signed(got.vel_y), got.reached);
        end
        reported++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [bzs_pkg::STEP_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bzs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD-1:0] cfg_data = '0;

  curve_tracker board = new;
  logic [COORD-1:0] cfg_words[7];
  bit steady = 1'b0;
  int hold_asks = 0;

  cubic_bezier_motion_stepper #(
    .COORD_BITS(COORD),
    .FRAC_BITS (FRAC)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [COORD-1:0] pick_coord();
    case ($urandom_range(7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return COORD'($urandom_range(0, 511) - 256);
      default: return COORD'($urandom());
    endcase
  endfunction

  task automatic wait_drained();
    while (board.pending_points.size() != 0) @(posedge clk);
  endtask

  // Offer one item, with an occasional gap in front of it.
  task automatic send_item(input action_t act, input logic [bzs_pkg::STEP_W-1:0] step);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= step;
    do @(posedge clk); while (!in_tready);
    board.note_item(act, step);
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_drained();
  endtask

  // Write all seven registers from cfg_words, and index 7 if asked, once idle.
  task automatic apply_cfg(input bit poke_unused);
    int n;
    n = poke_unused ? 8 : 7;
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i < 7) begin
        cfg_index <= REG_ORDER[i];
        cfg_data <= cfg_words[i];
      end else begin
        cfg_index <= REG_UNUSED;
        cfg_data <= COORD'($urandom());
      end
      do @(posedge clk); while (!cfg_ready);
      board.write_reg(cfg_index, cfg_data);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_points(input logic [COORD-1:0] v, input logic [COORD-1:0] dur_word);
    for (int i = 0; i < 6; i++) cfg_words[i] = v;
    cfg_words[6] = dur_word;
  endtask

  // Result side: check each accepted item and stall at random or on request.
  initial begin : receiver
    int hold_left;
    int holds_seen;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) board.check_point(out_tdata, out_tuser);
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Ends the run when no channel has moved an item for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int span;
    int dur;
    int items;
    int max_step;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the point sits at the origin.
    send_item(ACT_TICK, 16'd0);

    // Zero duration counts as one: start, exact end point, then past the end.
    cfg_words = '{24'd1000, -24'd2000, -24'd3000, 24'd4000, 24'd5000, -24'd7000, 24'd0};
    apply_cfg(1'b1);
    send_item(ACT_TICK, 16'd0);
    send_item(ACT_TICK, 16'd1);
    send_item(ACT_TICK, 16'd1);
    send_item(ACT_TICK, 16'd0);

    // Jumps between the corners of the range saturate the velocity both ways.
    fill_points(COORD_MIN, 24'd2);
    apply_cfg(1'b0);
    send_item(ACT_TICK, 16'd0);
    fill_points(COORD_MAX, 24'd2);
    apply_cfg(1'b0);
    send_item(ACT_TICK, 16'd0);
    fill_points(COORD_MIN, 24'd2);
    apply_cfg(1'b0);
    send_item(ACT_TICK, 16'd0);

    // Extreme control points over the longest move; duration upper bits are don't care.
    cfg_words = '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                  24'hFFFFFF};
    apply_cfg(1'b0);
    send_item(ACT_TICK, 16'd0);
    send_item(ACT_TICK, 16'd1);
    send_item(ACT_TICK, 16'd2);
    send_item(ACT_TICK, 16'd3);
    send_item(ACT_TICK, 16'h05A5);

    // Exactly half way along the same curve.
    cfg_words[6] = 24'(2 * board.elapsed);
    apply_cfg(1'b0);
    send_item(ACT_TICK, 16'd0);

    // Random curves, each swept from its current t toward and past the end.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int r = 0; r < 6; r++) cfg_words[r] = pick_coord();
      span = $urandom_range(100, 3000);
      dur = board.elapsed + span;
      if (dur > 65535) dur = 65535;
      cfg_words[6] = {8'($urandom()), 16'(dur)};
      apply_cfg(ph % 3 == 0);
      steady = (ph == 7);
      items = $urandom_range(100, 150);
      max_step = 2 * span / items + 1;
      for (int k = 0; k < items; k++) begin
        if (k == 40 && (ph == 3 || ph == 9)) hold_asks++;
        if (k == 70 && (ph == 5 || ph == 10)) pause_until_drained();
        send_item(ACT_TICK, 16'($urandom_range(0, max_step)));
      end
      steady = 1'b0;
    end

    // Large steps carry the move far past its end.
    for (int r = 0; r < 6; r++) cfg_words[r] = pick_coord();
    cfg_words[6] = COORD'($urandom());
    apply_cfg(1'b0);
    steady = 1'b1;
    for (int k = 0; k < FAR_TICKS; k++)
      send_item(ACT_TICK, (k % 16 == 0) ? 16'($urandom()) : 16'hFFFF);
    send_item(ACT_TICK, 16'h0000);
    steady = 1'b0;

    // A stop ends the move for good; later ticks and stops are absorbed.
    send_item(ACT_STOP, 16'($urandom()));
    for (int k = 0; k < 5; k++) send_item(ACT_TICK, 16'($urandom()));
    send_item(ACT_STOP, 16'($urandom()));
    for (int k = 0; k < 3; k++) send_item(ACT_TICK, 16'($urandom()));

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.bad_points == 0 && board.pending_points.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
sv/bzs_pkg.sv
sv/bzs_divider.sv
sv/bzs_lerp_unit.sv
sv/cubic_bezier_motion_stepper.sv
bench/cubic_bezier_motion_stepper_test.sv
